>>> design/mwo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwo_pkg
// shared types, constants and helpers for the multi-waveform oscillator
// ----------------------------------------------------------------------------
package mwo_pkg;

    localparam int SINE_DEPTH_DEF = 1024;

    localparam int MUL_AW = 64;
    localparam int MUL_BW = 48;
    localparam int MUL_CW = 6;

    localparam logic [31:0] TIME_STEP_RESET = 32'd89478;

    localparam logic REG_WAVEFORM  = 1'b0;
    localparam logic REG_TIME_STEP = 1'b1;

    localparam logic [2:0] WAVE_SINE     = 3'd0;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
    localparam logic [2:0] WAVE_SAW      = 3'd2;
    localparam logic [2:0] WAVE_SQUARE   = 3'd3;
    localparam logic [2:0] WAVE_FM       = 3'd4;

    localparam logic [1:0] OP_THREE   = 2'd0;
    localparam logic [1:0] OP_TWO     = 2'd1;
    localparam logic [1:0] OP_ONE     = 2'd2;
    localparam logic [1:0] OP_CARRIER = 2'd3;

    localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;

    typedef struct packed {
        logic              start;
        logic [MUL_CW-1:0] nbits;
    } mul_req_t;

    typedef enum logic [2:0] {
        SN_IDLE,
        SN_SQUARE,
        SN_POLY,
        SN_FINAL
    } sine_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LATCH,
        ST_ADVANCE,
        ST_PHASE,
        ST_SINE,
        ST_FM_RATIO,
        ST_FM_PHASE,
        ST_FM_SINE,
        ST_FM_DEPTH,
        ST_LEVEL,
        ST_EMIT
    } osc_state_t;

    function automatic logic [31:0] sine_coef(input logic [2:0] k);
        logic [31:0] c;
        case (k)
            3'd0:    c = 32'd172272;
            3'd1:    c = 32'd5026995;
            3'd2:    c = 32'd85569306;
            3'd3:    c = 32'd693598668;
            3'd4:    c = 32'd1686629713;
            default: c = 32'd0;
        endcase
        return c;
    endfunction

    // clamp to +-1.0, scale by 127, offset 128, round half up
    function automatic logic [7:0] to_level(input logic signed [33:0] v);
        logic signed [33:0] vc;
        logic signed [40:0] vx;
        logic signed [40:0] t;
        if (v > Q30_ONE)
            vc = Q30_ONE;
        else if (v < -Q30_ONE)
            vc = -Q30_ONE;
        else
            vc = v;
        vx = $signed({{7{vc[33]}}, vc});
        t  = 41'sd137975824384 + (vx <<< 7) - vx;
        return t[37:30];
    endfunction

endpackage

>>> design/mwo_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwo_mul
// bit-serial shift-add multiplier, one multiplier bit per cycle, product mod 2^64
// ----------------------------------------------------------------------------
module mwo_mul
    import mwo_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mul_req_t          req,
    input  logic [MUL_AW-1:0] a,
    input  logic [MUL_BW-1:0] b,
    output logic              done,
    output logic [MUL_AW-1:0] product
);

    logic [MUL_AW-1:0] acc_reg;
    logic [MUL_AW-1:0] m_reg;
    logic [MUL_BW-1:0] b_reg;
    logic [MUL_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.nbits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MUL_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= '0;
            m_reg   <= a;
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
                acc_reg <= acc_reg + m_reg;
            m_reg <= m_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("multiplier done without a run");

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("multiplier restarted while busy");

    a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cnt_reg == '0)
        else $error("multiplier count left over");

endmodule

>>> design/mwo_sine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwo_sine
// quarter-wave odd polynomial sine, Q2.30 result, on a bit-serial multiplier
// ----------------------------------------------------------------------------
module mwo_sine
    import mwo_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        phase,
    output logic               done,
    output logic signed [32:0] value
);

    localparam int DEPTH_LOG = $clog2(SINE_TABLE_DEPTH);
    localparam logic [31:0] PQ_MASK = ~((32'd1 << (32 - DEPTH_LOG)) - 32'd1);

    sine_state_t state_reg, state_next;

    logic [30:0]        z_reg;
    logic [30:0]        z2_reg;
    logic [2:0]         k_reg;
    logic               neg_reg;
    logic               done_reg;
    logic signed [32:0] value_reg;

    mul_req_t          mul_req;
    logic [MUL_AW-1:0] mul_a;
    logic [MUL_BW-1:0] mul_b;
    logic              mul_done;
    logic [MUL_AW-1:0] mul_product;

    logic [31:0] pq;
    logic [30:0] z_in;
    logic [30:0] z2_in;
    logic [31:0] s_new;
    logic [31:0] mag;

    mwo_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    assign pq    = phase & PQ_MASK;
    assign z_in  = pq[30] ? (31'h4000_0000 - {1'b0, pq[29:0]}) : {1'b0, pq[29:0]};
    assign z2_in = mul_product[60:30];
    assign s_new = sine_coef(k_reg) - mul_product[61:30];
    assign mag   = mul_product[61:30];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SN_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == SN_FINAL) && mul_done;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        mul_req.start = 1'b0;
        mul_req.nbits = MUL_CW'(31);
        mul_a         = '0;
        mul_b         = '0;
        case (state_reg)
            SN_IDLE:
            begin
                if (start)
                begin
                    mul_req.start = 1'b1;
                    mul_a         = MUL_AW'(z_in);
                    mul_b         = MUL_BW'(z_in);
                    state_next    = SN_SQUARE;
                end
            end
            SN_SQUARE:
            begin
                if (mul_done)
                begin
                    mul_req.start = 1'b1;
                    mul_a         = MUL_AW'(sine_coef(3'd0));
                    mul_b         = MUL_BW'(z2_in);
                    state_next    = SN_POLY;
                end
            end
            SN_POLY:
            begin
                if (mul_done)
                begin
                    mul_req.start = 1'b1;
                    mul_a         = MUL_AW'(s_new);
                    if (k_reg == 3'd4)
                    begin
                        mul_b      = MUL_BW'(z_reg);
                        state_next = SN_FINAL;
                    end
                    else
                        mul_b = MUL_BW'(z2_reg);
                end
            end
            SN_FINAL:
            begin
                if (mul_done)
                    state_next = SN_IDLE;
            end
            default: state_next = SN_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            SN_IDLE:
            begin
                if (start)
                begin
                    z_reg   <= z_in;
                    neg_reg <= pq[31];
                end
            end
            SN_SQUARE:
            begin
                if (mul_done)
                begin
                    z2_reg <= z2_in;
                    k_reg  <= 3'd1;
                end
            end
            SN_POLY:
            begin
                if (mul_done)
                    k_reg <= k_reg + 3'd1;
            end
            SN_FINAL:
            begin
                if (mul_done)
                    value_reg <= neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            end
            default: ;
        endcase
    end

    assign done  = done_reg;
    assign value = value_reg;

endmodule

>>> design/multi_waveform_oscillator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_waveform_oscillator
// sine, triangle, saw, square and three-operator fm audio oscillator
//
//   channel | direction | beat content
//   s_*     | in        | tuser freq_valid, tdata frequency, duty, fm ratios/depths
//   m_*     | out       | tuser sample_valid, tdata sample_level
//   cfg_*   | in        | register index and write data, no wait
//
// one beat is processed at a time through a bit-serial multiplier, one bit per cycle
// the sine unit spends six 31-bit serial multiplies; fm runs four operators
// reset clears time, held frequency and registers at once, no clearing pass
// input stalls while a beat is in work; a stalled output holds its beat
// ----------------------------------------------------------------------------
module multi_waveform_oscillator
    import mwo_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // frequency, duty, mod_ratio_one, mod_index_one, mod_ratio_two,
    // mod_index_two, mod_ratio_three, mod_index_three, one pad bit
    input  logic [151:0] s_tdata,
    // freq_valid
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // sample_level
    output logic [7:0]   m_tdata,
    // sample_valid
    output logic         m_tuser,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);

    osc_state_t state_reg, state_next;

    logic [2:0]  waveform_reg;
    logic [31:0] time_step_reg;
    logic [39:0] elapsed_reg;
    logic [22:0] held_reg;
    logic        out_valid_reg;
    logic [7:0]  out_level_reg;
    logic        out_flag_reg;

    logic               fv_reg;
    logic [22:0]        freq_reg;
    logic [7:0]         duty_reg;
    logic signed [15:0] r1_reg, r2_reg, r3_reg;
    logic signed [23:0] i1_reg, i2_reg, i3_reg;
    logic [1:0]         op_reg;
    logic               neg_reg;
    logic signed [33:0] v3_reg;
    logic signed [33:0] vsum_reg;
    logic signed [33:0] val_reg;
    logic               res_flag_reg;
    logic [7:0]         res_level_reg;

    mul_req_t          mul_req;
    logic [MUL_AW-1:0] mul_a;
    logic [MUL_BW-1:0] mul_b;
    logic              mul_done;
    logic [MUL_AW-1:0] mul_product;

    logic               sine_start;
    logic [31:0]        sine_phase;
    logic               sine_done;
    logic signed [32:0] sine_value;

    logic               accept;
    logic               out_free;
    logic               over_period;
    logic [39:0]        elapsed_sum;
    logic [31:0]        freq_word;
    logic [31:0]        tri_g;
    logic signed [33:0] tri_val;
    logic [32:0]        saw_span;
    logic signed [33:0] saw_val;
    logic signed [33:0] sq_val;
    logic signed [15:0] next_ratio;
    logic signed [23:0] cur_index;
    logic [23:0]        index_abs;
    logic [32:0]        sine_abs;
    logic [32:0]        depth_mag;
    logic signed [33:0] depth_val;
    logic [47:0]        f16_ratio;
    logic signed [33:0] vsum_all;
    logic [47:0]        f16_carrier;

    mwo_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    mwo_sine #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sine_start),
        .phase (sine_phase),
        .done  (sine_done),
        .value (sine_value)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_level_reg;
    assign m_tuser  = out_flag_reg;

    assign over_period = (|mul_product[63:41]) || (mul_product[40] && (|mul_product[39:0]));
    assign elapsed_sum = elapsed_reg + {8'd0, time_step_reg};
    assign freq_word   = mul_product[39:8];

    // triangle from the phase shifted by a quarter turn
    assign tri_g    = freq_word + 32'h4000_0000;
    assign tri_val  = $signed({1'b0, (tri_g[31] ? (33'h1_0000_0000 - {1'b0, tri_g})
                                                : {1'b0, tri_g})}) - Q30_ONE;
    assign saw_span = 33'h1_0000_0000 - {1'b0, freq_word};
    assign saw_val  = freq_word[31] ? -$signed({2'b00, saw_span[32:1]})
                                    : $signed({3'b000, freq_word[31:1]});
    assign sq_val   = (freq_word < {duty_reg, 24'd0}) ? Q30_ONE : -Q30_ONE;

    always_comb
    begin
        case (op_reg)
            OP_THREE:
            begin
                cur_index  = i3_reg;
                next_ratio = r2_reg;
            end
            OP_TWO:
            begin
                cur_index  = i2_reg;
                next_ratio = r1_reg;
            end
            OP_ONE:
            begin
                cur_index  = i1_reg;
                next_ratio = r1_reg;
            end
            default:
            begin
                cur_index  = i1_reg;
                next_ratio = r1_reg;
            end
        endcase
    end

    assign index_abs   = cur_index[23] ? (24'd0 - cur_index) : cur_index;
    assign sine_abs    = sine_value[32] ? (33'd0 - sine_value) : sine_value;
    assign depth_mag   = mul_product[54:22];
    assign depth_val   = neg_reg ? -$signed({1'b0, depth_mag}) : $signed({1'b0, depth_mag});
    assign f16_ratio   = mul_product[47:0]
                       + ((op_reg == OP_THREE) ? 48'd0 : {{14{v3_reg[33]}}, v3_reg});
    assign vsum_all    = vsum_reg + depth_val;
    assign f16_carrier = {17'd0, held_reg, 8'd0} + {{14{vsum_all[33]}}, vsum_all};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            waveform_reg  <= WAVE_SINE;
            time_step_reg <= TIME_STEP_RESET;
            elapsed_reg   <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WAVEFORM:  waveform_reg  <= cfg_data[2:0];
                    REG_TIME_STEP: time_step_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                ST_CHECK:
                begin
                    if (fv_reg && held_reg == '0)
                    begin
                        elapsed_reg <= {8'd0, elapsed_reg[31:0]};
                        held_reg    <= freq_reg;
                    end
                end
                ST_LATCH:
                begin
                    if (mul_done && over_period)
                    begin
                        elapsed_reg <= {8'd0, elapsed_reg[31:0]};
                        held_reg    <= freq_reg;
                    end
                end
                ST_ADVANCE: elapsed_reg <= elapsed_sum;
                default: ;
            endcase
            if (m_tvalid && m_tready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_EMIT && out_free)
                out_valid_reg <= 1'b1;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        mul_req.start = 1'b0;
        mul_req.nbits = MUL_CW'(48);
        mul_a         = '0;
        mul_b         = '0;
        sine_start    = 1'b0;
        sine_phase    = (state_reg == ST_PHASE) ? freq_word : mul_product[47:16];
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (fv_reg && held_reg != '0)
                begin
                    mul_req.start = 1'b1;
                    mul_req.nbits = MUL_CW'(23);
                    mul_a         = MUL_AW'(elapsed_reg);
                    mul_b         = MUL_BW'(held_reg);
                    state_next    = ST_LATCH;
                end
                else
                    state_next = ST_ADVANCE;
            end
            ST_LATCH:
            begin
                if (mul_done)
                    state_next = ST_ADVANCE;
            end
            ST_ADVANCE:
            begin
                if (!fv_reg || waveform_reg > WAVE_FM)
                    state_next = ST_EMIT;
                else
                begin
                    mul_req.start = 1'b1;
                    mul_req.nbits = MUL_CW'(23);
                    mul_a         = MUL_AW'(elapsed_sum);
                    mul_b         = MUL_BW'(held_reg);
                    state_next    = ST_PHASE;
                end
            end
            ST_PHASE:
            begin
                if (mul_done)
                begin
                    case (waveform_reg)
                        WAVE_SINE:
                        begin
                            sine_start = 1'b1;
                            state_next = ST_SINE;
                        end
                        WAVE_FM:
                        begin
                            mul_req.start = 1'b1;
                            mul_a         = MUL_AW'(held_reg);
                            mul_b         = MUL_BW'($signed(r3_reg));
                            state_next    = ST_FM_RATIO;
                        end
                        default: state_next = ST_LEVEL;
                    endcase
                end
            end
            ST_SINE:
            begin
                if (sine_done)
                    state_next = ST_LEVEL;
            end
            ST_FM_RATIO:
            begin
                if (mul_done)
                begin
                    mul_req.start = 1'b1;
                    mul_a         = MUL_AW'(elapsed_reg);
                    mul_b         = f16_ratio;
                    state_next    = ST_FM_PHASE;
                end
            end
            ST_FM_PHASE:
            begin
                if (mul_done)
                begin
                    sine_start = 1'b1;
                    state_next = ST_FM_SINE;
                end
            end
            ST_FM_SINE:
            begin
                if (sine_done)
                begin
                    if (op_reg == OP_CARRIER)
                        state_next = ST_LEVEL;
                    else
                    begin
                        mul_req.start = 1'b1;
                        mul_req.nbits = MUL_CW'(33);
                        mul_a         = MUL_AW'(index_abs);
                        mul_b         = MUL_BW'(sine_abs);
                        state_next    = ST_FM_DEPTH;
                    end
                end
            end
            ST_FM_DEPTH:
            begin
                if (mul_done)
                begin
                    mul_req.start = 1'b1;
                    if (op_reg == OP_ONE)
                    begin
                        mul_a      = MUL_AW'(elapsed_reg);
                        mul_b      = f16_carrier;
                        state_next = ST_FM_PHASE;
                    end
                    else
                    begin
                        mul_a      = MUL_AW'(held_reg);
                        mul_b      = MUL_BW'($signed(next_ratio));
                        state_next = ST_FM_RATIO;
                    end
                end
            end
            ST_LEVEL: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fv_reg   <= s_tuser;
            freq_reg <= s_tdata[22:0];
            duty_reg <= s_tdata[30:23];
            r1_reg   <= s_tdata[46:31];
            i1_reg   <= s_tdata[70:47];
            r2_reg   <= s_tdata[86:71];
            i2_reg   <= s_tdata[110:87];
            r3_reg   <= s_tdata[126:111];
            i3_reg   <= s_tdata[150:127];
        end
        case (state_reg)
            ST_ADVANCE:
            begin
                if (!fv_reg)
                begin
                    res_flag_reg  <= 1'b0;
                    res_level_reg <= 8'd0;
                end
                else if (waveform_reg > WAVE_FM)
                begin
                    res_flag_reg  <= 1'b1;
                    res_level_reg <= 8'd128;
                end
            end
            ST_PHASE:
            begin
                if (mul_done)
                begin
                    case (waveform_reg)
                        WAVE_TRIANGLE: val_reg <= tri_val;
                        WAVE_SAW:      val_reg <= saw_val;
                        WAVE_SQUARE:   val_reg <= sq_val;
                        WAVE_FM:       op_reg  <= OP_THREE;
                        default: ;
                    endcase
                end
            end
            ST_SINE:
            begin
                if (sine_done)
                    val_reg <= {sine_value[32], sine_value};
            end
            ST_FM_SINE:
            begin
                if (sine_done)
                begin
                    if (op_reg == OP_CARRIER)
                        val_reg <= {sine_value[32], sine_value};
                    else
                        neg_reg <= cur_index[23] ^ sine_value[32];
                end
            end
            ST_FM_DEPTH:
            begin
                if (mul_done)
                begin
                    case (op_reg)
                        OP_THREE:
                        begin
                            v3_reg <= depth_val;
                            op_reg <= OP_TWO;
                        end
                        OP_TWO:
                        begin
                            vsum_reg <= depth_val;
                            op_reg   <= OP_ONE;
                        end
                        default: op_reg <= OP_CARRIER;
                    endcase
                end
            end
            ST_LEVEL:
            begin
                res_flag_reg  <= 1'b1;
                res_level_reg <= to_level(val_reg);
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_level_reg <= res_level_reg;
                    out_flag_reg  <= res_flag_reg;
                end
            end
            default: ;
        endcase
    end

    a_mul_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_LATCH || state_reg == ST_PHASE ||
                      state_reg == ST_FM_RATIO || state_reg == ST_FM_PHASE ||
                      state_reg == ST_FM_DEPTH))
        else $error("multiplier result with nobody waiting");

    a_sine_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        sine_done |-> (state_reg == ST_SINE || state_reg == ST_FM_SINE))
        else $error("sine result with nobody waiting");

    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_CHECK)
        else $error("accepted beat not checked");

    a_held_changes_on_latch: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg != $past(held_reg) |->
            ($past(state_reg) == ST_CHECK || $past(state_reg) == ST_LATCH))
        else $error("held frequency changed outside latch");

endmodule
